FILE: rtl/core/rbpt_pkg.sv
// Shared types, widths and helpers for the rigid-body point transform.
// Depends on nothing; the top level refers to it by scoped names.
package rbpt_pkg;

    localparam int COORD_W = 32;   // Q16.16 coordinates and translation
    localparam int QUAT_W  = 32;   // Q2.30 quaternion parts
    localparam int IDX_W   = 3;    // configuration register index

    localparam int FRAC_Q  = 30;   // fraction bits of a quaternion part

    // q * v products and their rounded values
    localparam int PROD1_W = QUAT_W + COORD_W;   // 64
    localparam int RND1_W  = 34;
    localparam int CROSS_W = RND1_W + 1;         // first cross product
    // q * c products and their rounded values
    localparam int PROD2_W = QUAT_W + CROSS_W;   // 67
    localparam int RND2_W  = 36;
    localparam int TERM_W  = RND2_W + 1;         // second cross product, w*c term
    localparam int SUM_W   = 40;                 // final sum before saturation

    localparam logic signed [QUAT_W-1:0]  Q_ONE  = QUAT_W'(64'sd1073741824);
    localparam logic signed [PROD2_W-1:0] Q_HALF = PROD2_W'(64'sd536870912);

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

    // Cyclic successor indices used by the cross products: x->y->z->x
    localparam int NEXT1 [3] = '{1, 2, 0};
    localparam int NEXT2 [3] = '{2, 0, 1};

    typedef enum logic [IDX_W-1:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } t_reg_idx;

    // Limit a quaternion part to [-1.0, +1.0]
    function automatic logic signed [QUAT_W-1:0] clamp_q(input logic signed [QUAT_W-1:0] a);
        logic signed [QUAT_W-1:0] res;
        res = a;
        if (a > Q_ONE) begin
            res = Q_ONE;
        end else if (a < -Q_ONE) begin
            res = -Q_ONE;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/rigid_body_point_transform_top.sv
// Rigid-body point transform: quaternion rotation plus translation, six-stage pipeline.
// Depends on rbpt_pkg for widths, register indexes and the clamp helper.
//
// Usage:
//   Input channel  : i_in_valid / o_in_ready carry one point word (i_in_x, i_in_y, i_in_z),
//                    signed Q16.16. A word is taken at a clock edge with valid and ready high.
//   Output channel : o_out_valid / i_out_ready carry one result word (o_out_x/y/z, Q16.16,
//                    saturated, and o_clipped, set when any coordinate hit a bound).
//   Config port    : i_cfg_we, i_cfg_idx, i_cfg_data. Indexes 0..3 load rot_w/x/y/z (Q2.30),
//                    4..6 load shift_x/y/z (Q16.16); index 7 is dropped. Write only while the
//                    pipeline is empty. Quaternion parts are clamped to [-1.0, +1.0] on write.
//   Throughput     : one point per cycle, sustained while the output word is taken or the output register is free.
//   Stages         : six register stages from the accepting edge to o_out_valid: q*v multiply,
//                    first cross product, q*c multiply, second cross product and w*c term,
//                    final sum, saturation into the output register.
//   Stall          : when the output word is held and not taken, every stage holds and
//                    o_in_ready drops; nothing is lost or repeated. A free output register
//                    keeps the pipeline moving.
//   Reset          : synchronous, active low; empties the pipeline and loads the identity
//                    quaternion (w = 1.0) with zero translation.
module rigid_body_point_transform_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [rbpt_pkg::IDX_W-1:0]           i_cfg_idx,
    input  logic [rbpt_pkg::COORD_W-1:0]         i_cfg_data,
    // input point
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [rbpt_pkg::COORD_W-1:0]  i_in_x,
    input  logic signed [rbpt_pkg::COORD_W-1:0]  i_in_y,
    input  logic signed [rbpt_pkg::COORD_W-1:0]  i_in_z,
    // result
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rbpt_pkg::COORD_W-1:0]  o_out_x,
    output logic signed [rbpt_pkg::COORD_W-1:0]  o_out_y,
    output logic signed [rbpt_pkg::COORD_W-1:0]  o_out_z,
    output logic                                 o_clipped
);

    localparam int CW  = rbpt_pkg::COORD_W;
    localparam int QW  = rbpt_pkg::QUAT_W;
    localparam int P1W = rbpt_pkg::PROD1_W;
    localparam int R1W = rbpt_pkg::RND1_W;
    localparam int XW  = rbpt_pkg::CROSS_W;
    localparam int P2W = rbpt_pkg::PROD2_W;
    localparam int R2W = rbpt_pkg::RND2_W;
    localparam int TW  = rbpt_pkg::TERM_W;
    localparam int SW  = rbpt_pkg::SUM_W;
    localparam int FQ  = rbpt_pkg::FRAC_Q;

    // ------------------------------------------------------------------
    // Configuration registers (quaternion kept pre-clamped)
    // ------------------------------------------------------------------
    logic signed [QW-1:0] r_qw;
    logic signed [QW-1:0] r_qv [3];     // x, y, z vector part
    logic signed [CW-1:0] r_shift [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw <= rbpt_pkg::Q_ONE;
            for (int k = 0; k < 3; k++) begin
                r_qv[k]    <= '0;
                r_shift[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (rbpt_pkg::t_reg_idx'(i_cfg_idx))
                rbpt_pkg::REG_ROT_W:   r_qw       <= rbpt_pkg::clamp_q(i_cfg_data);
                rbpt_pkg::REG_ROT_X:   r_qv[0]    <= rbpt_pkg::clamp_q(i_cfg_data);
                rbpt_pkg::REG_ROT_Y:   r_qv[1]    <= rbpt_pkg::clamp_q(i_cfg_data);
                rbpt_pkg::REG_ROT_Z:   r_qv[2]    <= rbpt_pkg::clamp_q(i_cfg_data);
                rbpt_pkg::REG_SHIFT_X: r_shift[0] <= i_cfg_data;
                rbpt_pkg::REG_SHIFT_Y: r_shift[1] <= i_cfg_data;
                rbpt_pkg::REG_SHIFT_Z: r_shift[2] <= i_cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages advance together unless the output
    // word is held by the receiver.
    // ------------------------------------------------------------------
    logic w_adv;
    logic r_out_valid;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_out_valid;

    logic signed [CW-1:0] w_in_v [3];
    assign w_in_v[0] = i_in_x;
    assign w_in_v[1] = i_in_y;
    assign w_in_v[2] = i_in_z;

    // Stage 1: q * v products, a pair per cross-product lane
    logic                  r_s1_valid;
    logic signed [CW-1:0]  r_s1_v  [3];
    logic signed [P1W-1:0] r_s1_pa [3];   // q[next1] * v[next2]
    logic signed [P1W-1:0] r_s1_pb [3];   // q[next2] * v[next1]

    // Stage 2: first cross product c = q x v
    logic                  r_s2_valid;
    logic signed [CW-1:0]  r_s2_v [3];
    logic signed [XW-1:0]  r_s2_c [3];

    // Stage 3: q * c products and w * c
    logic                  r_s3_valid;
    logic signed [CW-1:0]  r_s3_v  [3];
    logic signed [P2W-1:0] r_s3_pa [3];
    logic signed [P2W-1:0] r_s3_pb [3];
    logic signed [P2W-1:0] r_s3_pw [3];

    // Stage 4: second cross product d = q x c and rounded w * c
    logic                  r_s4_valid;
    logic signed [CW-1:0]  r_s4_v [3];
    logic signed [TW-1:0]  r_s4_d [3];
    logic signed [TW-1:0]  r_s4_m [3];

    // Stage 5: unsaturated result
    logic                  r_s5_valid;
    logic signed [SW-1:0]  r_s5_r [3];

    // Output register
    logic signed [CW-1:0]  r_out [3];
    logic                  r_clip;

    // ------------------------------------------------------------------
    // Next-value logic for the payload
    // ------------------------------------------------------------------
    logic signed [P1W-1:0] n_s1_pa [3];
    logic signed [P1W-1:0] n_s1_pb [3];
    logic signed [XW-1:0]  n_s2_c  [3];
    logic signed [P2W-1:0] n_s3_pa [3];
    logic signed [P2W-1:0] n_s3_pb [3];
    logic signed [P2W-1:0] n_s3_pw [3];
    logic signed [TW-1:0]  n_s4_d  [3];
    logic signed [TW-1:0]  n_s4_m  [3];
    logic signed [SW-1:0]  n_s5_r  [3];
    logic signed [CW-1:0]  n_out   [3];
    logic [2:0]            n_clip_lane;

    always_comb begin
        logic signed [P1W-1:0] ra1, rb1;
        logic signed [P2W-1:0] ra2, rb2, rw2;
        logic signed [TW-1:0]  s;
        for (int i = 0; i < 3; i++) begin
            // q * v
            n_s1_pa[i] = r_qv[rbpt_pkg::NEXT1[i]] * w_in_v[rbpt_pkg::NEXT2[i]];
            n_s1_pb[i] = r_qv[rbpt_pkg::NEXT2[i]] * w_in_v[rbpt_pkg::NEXT1[i]];

            // round each product half up, then take the difference
            ra1 = r_s1_pa[i] + P1W'(rbpt_pkg::Q_HALF);
            rb1 = r_s1_pb[i] + P1W'(rbpt_pkg::Q_HALF);
            n_s2_c[i] = XW'($signed(ra1[FQ +: R1W])) - XW'($signed(rb1[FQ +: R1W]));

            // q * c and w * c
            n_s3_pa[i] = r_qv[rbpt_pkg::NEXT1[i]] * r_s2_c[rbpt_pkg::NEXT2[i]];
            n_s3_pb[i] = r_qv[rbpt_pkg::NEXT2[i]] * r_s2_c[rbpt_pkg::NEXT1[i]];
            n_s3_pw[i] = r_qw * r_s2_c[i];

            ra2 = r_s3_pa[i] + rbpt_pkg::Q_HALF;
            rb2 = r_s3_pb[i] + rbpt_pkg::Q_HALF;
            rw2 = r_s3_pw[i] + rbpt_pkg::Q_HALF;
            n_s4_d[i] = TW'($signed(ra2[FQ +: R2W])) - TW'($signed(rb2[FQ +: R2W]));
            n_s4_m[i] = TW'($signed(rw2[FQ +: R2W]));

            // v + 2 * (w*c + d) + shift
            s = r_s4_m[i] + r_s4_d[i];
            n_s5_r[i] = SW'(r_s4_v[i]) + (SW'(s) <<< 1) + SW'(r_shift[i]);

            // saturate to 32 bits
            n_clip_lane[i] = 1'b1;
            if (r_s5_r[i] > rbpt_pkg::SAT_MAX) begin
                n_out[i] = CW'(rbpt_pkg::SAT_MAX);
            end else if (r_s5_r[i] < rbpt_pkg::SAT_MIN) begin
                n_out[i] = CW'(rbpt_pkg::SAT_MIN);
            end else begin
                n_out[i]       = CW'(r_s5_r[i]);
                n_clip_lane[i] = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid chain: clear on reset, advance on w_adv
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
        end
    end

    // Payload: no reset, hold on stall
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_v[i]  <= w_in_v[i];
                r_s1_pa[i] <= n_s1_pa[i];
                r_s1_pb[i] <= n_s1_pb[i];
                r_s2_v[i]  <= r_s1_v[i];
                r_s2_c[i]  <= n_s2_c[i];
                r_s3_v[i]  <= r_s2_v[i];
                r_s3_pa[i] <= n_s3_pa[i];
                r_s3_pb[i] <= n_s3_pb[i];
                r_s3_pw[i] <= n_s3_pw[i];
                r_s4_v[i]  <= r_s3_v[i];
                r_s4_d[i]  <= n_s4_d[i];
                r_s4_m[i]  <= n_s4_m[i];
                r_s5_r[i]  <= n_s5_r[i];
                r_out[i]   <= n_out[i];
            end
            r_clip <= |n_clip_lane;
        end
    end

    assign o_out_x   = r_out[0];
    assign o_out_y   = r_out[1];
    assign o_out_z   = r_out[2];
    assign o_clipped = r_clip;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A flagged result carries at least one coordinate at a bound
    a_clip_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_clip) |->
            (r_out[0] == CW'(rbpt_pkg::SAT_MAX) || r_out[0] == CW'(rbpt_pkg::SAT_MIN) ||
             r_out[1] == CW'(rbpt_pkg::SAT_MAX) || r_out[1] == CW'(rbpt_pkg::SAT_MIN) ||
             r_out[2] == CW'(rbpt_pkg::SAT_MAX) || r_out[2] == CW'(rbpt_pkg::SAT_MIN)))
        else $error("clip flag set without a saturated coordinate");

    // A stalled pipeline holds its last-stage sum (lanes x and z are checked)
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_valid && !w_adv) |=> (r_s5_valid && $stable(r_s5_r[0]) && $stable(r_s5_r[2])))
        else $error("stage 5 changed during a stall");

    // A word in stage 5 reaches the output register on the next advance
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_valid && w_adv) |=> r_out_valid)
        else $error("word lost between stage 5 and output");

    // Stored quaternion parts stay within [-1.0, +1.0]
    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qw <= rbpt_pkg::Q_ONE && r_qw >= -rbpt_pkg::Q_ONE &&
         r_qv[0] <= rbpt_pkg::Q_ONE && r_qv[0] >= -rbpt_pkg::Q_ONE &&
         r_qv[1] <= rbpt_pkg::Q_ONE && r_qv[1] >= -rbpt_pkg::Q_ONE &&
         r_qv[2] <= rbpt_pkg::Q_ONE && r_qv[2] >= -rbpt_pkg::Q_ONE))
        else $error("quaternion register outside clamp range");

endmodule

FILE: tb/sv/rbpt_tb_pkg.sv
// Checker types and the point transform scoreboard for the rigid-body transform bench.
// Depends on rbpt_pkg for the coordinate width, the index width and the register indexes.
package rbpt_tb_pkg;

    localparam logic [rbpt_pkg::IDX_W-1:0] CFG_IDX_SPARE = 3'd7;   // decodes to no register

    localparam longint UNIT_Q30  = 64'sd1073741824;
    localparam longint HALF_Q30  = 64'sd536870912;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    typedef logic signed [rbpt_pkg::COORD_W-1:0] coord_t;

    typedef struct {
        coord_t coord [3];
        logic   clipped;
    } point_result_t;

    class point_transform_checker;
        coord_t        quat [4];      // w, x, y, z as written
        coord_t        shift [3];
        point_result_t expected_points [$];
        int            errors;
        int            points_noted;
        int            results_checked;

        function new();
            quat    = '{coord_t'(UNIT_Q30), 0, 0, 0};
            shift   = '{0, 0, 0};
            errors  = 0;
            points_noted    = 0;
            results_checked = 0;
        endfunction

        function void set_reg(logic [rbpt_pkg::IDX_W-1:0] idx,
                              logic [rbpt_pkg::COORD_W-1:0] data);
            case (idx)
                rbpt_pkg::REG_ROT_W:   quat[0]  = data;
                rbpt_pkg::REG_ROT_X:   quat[1]  = data;
                rbpt_pkg::REG_ROT_Y:   quat[2]  = data;
                rbpt_pkg::REG_ROT_Z:   quat[3]  = data;
                rbpt_pkg::REG_SHIFT_X: shift[0] = data;
                rbpt_pkg::REG_SHIFT_Y: shift[1] = data;
                rbpt_pkg::REG_SHIFT_Z: shift[2] = data;
                default: ;
            endcase
        endfunction

        function longint limit_unit(coord_t a);
            longint v;
            v = longint'(a);
            if (v > UNIT_Q30) begin
                v = UNIT_Q30;
            end else if (v < -UNIT_Q30) begin
                v = -UNIT_Q30;
            end
            return v;
        endfunction

        // Q2.30 times Q16.16, rounded half up back to Q16.16
        function longint round_q30(longint q, longint v);
            return (q * v + HALF_Q30) >>> 30;
        endfunction

        function void note_point(coord_t px, coord_t py, coord_t pz);
            longint        q [4];
            longint        v [3];
            longint        c [3];
            longint        d [3];
            longint        r;
            int            n1;
            int            n2;
            point_result_t res;
            foreach (q[i]) q[i] = limit_unit(quat[i]);
            v[0] = longint'(px);
            v[1] = longint'(py);
            v[2] = longint'(pz);
            // axis a uses quaternion part a+1
            for (int i = 0; i < 3; i++) begin
                n1 = (i + 1) % 3;
                n2 = (i + 2) % 3;
                c[i] = round_q30(q[n1 + 1], v[n2]) - round_q30(q[n2 + 1], v[n1]);
            end
            for (int i = 0; i < 3; i++) begin
                n1 = (i + 1) % 3;
                n2 = (i + 2) % 3;
                d[i] = round_q30(q[n1 + 1], c[n2]) - round_q30(q[n2 + 1], c[n1]);
            end
            res.clipped = 1'b0;
            for (int i = 0; i < 3; i++) begin
                r = v[i] + 2 * (round_q30(q[0], c[i]) + d[i]) + longint'(shift[i]);
                if (r > COORD_MAX) begin
                    r = COORD_MAX;
                    res.clipped = 1'b1;
                end else if (r < COORD_MIN) begin
                    r = COORD_MIN;
                    res.clipped = 1'b1;
                end
                res.coord[i] = coord_t'(r);
            end
            expected_points.push_back(res);
            points_noted++;
        endfunction

        function void check_result(coord_t ax, coord_t ay, coord_t az, logic aclip);
            point_result_t want;
            coord_t        got [3];
            string         field [3];
            field = '{"out_x", "out_y", "out_z"};
            got   = '{ax, ay, az};
            results_checked++;
            if (expected_points.size() == 0) begin
                $error("result word with no point pending: out_x %0d out_y %0d out_z %0d",
                       ax, ay, az);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got[i] !== want.coord[i]) begin
                    $error("%s expected %0d actual %0d", field[i], want.coord[i], got[i]);
                    errors++;
                end
            end
            if (aclip !== want.clipped) begin
                $error("clipped expected %0d actual %0d", want.clipped, aclip);
                errors++;
            end
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_top.sv
// Self-checking bench for rigid_body_point_transform_top: directed and random points under
// several register settings and handshake idle mixes. Depends on rbpt_pkg and rbpt_tb_pkg.
module tb_top;
    import rbpt_tb_pkg::*;

    localparam int SETTLE_CYCLES = 10;     // pipeline is six deep; leave a margin
    localparam int QUIET_LIMIT   = 4000;   // cycles without any accepted word
    localparam int PHASE_POINTS  = 200;
    localparam int RANDOM_PHASES = 8;
    localparam coord_t COS45     = 32'sd759250125;   // cos(45 deg) in Q2.30

    typedef enum {SET_IN_RANGE, SET_WILD, SET_EXTREME, SET_QUARTER_TURN} setting_kind_t;
    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mix_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                cfg_we   = 1'b0;
    logic [rbpt_pkg::IDX_W-1:0]          cfg_idx  = '0;
    logic [rbpt_pkg::COORD_W-1:0]        cfg_data = '0;

    logic   in_valid = 1'b0;
    logic   in_ready;
    coord_t in_x = '0;
    coord_t in_y = '0;
    coord_t in_z = '0;

    logic   out_valid;
    logic   out_ready = 1'b0;
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   out_clipped;

    int unsigned send_idle_pct  = 0;   // chance per cycle that the sender holds off
    int unsigned recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    int unsigned quiet_cycles   = 0;
    int          settings_loaded = 0;

    point_transform_checker sb = new();

    rigid_body_point_transform_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_x      (in_x),
        .i_in_y      (in_y),
        .i_in_z      (in_z),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_x     (out_x),
        .o_out_y     (out_y),
        .o_out_z     (out_z),
        .o_clipped   (out_clipped)
    );

    always #2 clk = ~clk;

    // Receiver: redraw ready at every falling edge so stalls land on any pipeline phase.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: note every accepted point word, check every accepted result word,
    // and count cycles in which neither channel moves.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            sb.note_point(in_x, in_y, in_z);
        end
        if (rst_n && out_valid && out_ready) begin
            sb.check_result(out_x, out_y, out_z, out_clipped);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run if the block stops moving words.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_x     <= x;
        in_y     <= y;
        in_z     <= z;
        // hold the word until the block takes it
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    // Drop valid, wait until every result word has come back, then let the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_points.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [rbpt_pkg::IDX_W-1:0] idx,
                             input logic [rbpt_pkg::COORD_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Load all seven registers back to back, plus one write to the unused index
    // that the block must drop.
    task automatic load_setting(input coord_t w, input coord_t qx, input coord_t qy,
                                input coord_t qz, input coord_t sx, input coord_t sy,
                                input coord_t sz);
        write_reg(rbpt_pkg::REG_ROT_W, w);
        write_reg(rbpt_pkg::REG_ROT_X, qx);
        write_reg(rbpt_pkg::REG_ROT_Y, qy);
        write_reg(rbpt_pkg::REG_SHIFT_X, sx);
        write_reg(CFG_IDX_SPARE, $urandom);
        write_reg(rbpt_pkg::REG_ROT_Z, qz);
        write_reg(rbpt_pkg::REG_SHIFT_Y, sy);
        write_reg(rbpt_pkg::REG_SHIFT_Z, sz);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic set_idle(input idle_mix_t mix);
        case (mix)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 51; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default:       begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    function automatic coord_t small_coord();
        return coord_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endfunction

    // Half full-range words, a good share of small ones that rarely clip, and extremes.
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return coord_t'($urandom);
            5, 6, 7, 8:    return small_coord();
            default: begin
                case ($urandom_range(0, 4))
                    0:       return coord_t'(COORD_MAX);
                    1:       return coord_t'(COORD_MIN);
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic load_random_setting(input setting_kind_t kind);
        coord_t q [4];
        coord_t s [3];
        case (kind)
            SET_IN_RANGE: begin
                foreach (q[i]) q[i] = coord_t'($urandom_range(0, 32'h8000_0000))
                                      - coord_t'(UNIT_Q30);
                foreach (s[i]) s[i] = small_coord();
            end
            SET_WILD: begin
                // parts beyond +-1.0 get clamped inside the block
                foreach (q[i]) q[i] = coord_t'($urandom);
                foreach (s[i]) s[i] = coord_t'($urandom);
            end
            SET_EXTREME: begin
                foreach (q[i]) begin
                    case ($urandom_range(0, 2))
                        0:       q[i] = coord_t'(UNIT_Q30);
                        1:       q[i] = -coord_t'(UNIT_Q30);
                        default: q[i] = 32'sd0;
                    endcase
                end
                foreach (s[i]) begin
                    case ($urandom_range(0, 2))
                        0:       s[i] = coord_t'(COORD_MAX);
                        1:       s[i] = coord_t'(COORD_MIN);
                        default: s[i] = 32'sd0;
                    endcase
                end
            end
            default: begin
                // true unit quaternion: quarter turn about a random axis
                q = '{COS45, 0, 0, 0};
                q[1 + $urandom_range(0, 2)] = $urandom_range(0, 1) ? COS45 : -COS45;
                foreach (s[i]) s[i] = small_coord();
            end
        endcase
        load_setting(q[0], q[1], q[2], q[3], s[0], s[1], s[2]);
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting is the identity: every point must come back unchanged.
        send_point(coord_t'(COORD_MAX), coord_t'(COORD_MIN), 32'sd0);
        send_point(coord_t'(COORD_MIN), coord_t'(COORD_MAX), -32'sd1);
        send_point(32'sd1, -32'sd1, 32'sd0);
        send_point(32'sd0, 32'sd0, 32'sd0);
        drain();

        // Out-of-range parts clamp to +-1.0; the result is a non-unit quaternion,
        // and the extreme shifts force saturation both ways.
        load_setting(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh4000_0001, 32'shBFFF_FFFF,
                     coord_t'(COORD_MAX), coord_t'(COORD_MIN), 32'sd0);
        send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        send_point(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN));
        send_point(coord_t'(COORD_MAX), coord_t'(COORD_MIN), 32'sd0);
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'sd1, -32'sd1, 32'sd1);
        send_point(coord_t'(COORD_MIN), coord_t'(COORD_MAX), -32'sd1);
        send_point(-32'sd1, 32'sd0, coord_t'(COORD_MAX));
        send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_8000);
        drain();

        // Half turn about x: y and z flip sign, so negating the most negative word clips.
        load_setting(32'sd0, coord_t'(UNIT_Q30), 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_point(32'sh0005_0000, coord_t'(COORD_MIN), coord_t'(COORD_MAX));
        send_point(32'sd0, coord_t'(COORD_MAX), coord_t'(COORD_MIN));
        send_point(-32'sd1, 32'sd1, -32'sd1);
        send_point(coord_t'(COORD_MIN), 32'sd0, 32'sd1);
        drain();

        // Half-valued parts on odd LSB inputs: exercise round half up on both signs.
        load_setting(coord_t'(HALF_Q30), 32'sd0, 32'sd0, coord_t'(HALF_Q30),
                     32'sd0, 32'sd0, 32'sd0);
        send_point(32'sd1, -32'sd1, 32'sd3);
        send_point(-32'sd1, 32'sd1, -32'sd3);
        send_point(32'sd3, 32'sd5, -32'sd7);
        send_point(-32'sd3, -32'sd5, 32'sd7);
        send_point(32'sd1, 32'sd0, 32'sd0);
        send_point(32'sd0, -32'sd1, 32'sd0);
        drain();

        // Random phases: pair each kind of setting with a different idle mix over the run.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_random_setting(setting_kind_t'(phase % 4));
            set_idle(idle_mix_t'((phase + phase / 4) % 4));
            repeat (PHASE_POINTS) send_point(pick_coord(), pick_coord(), pick_coord());
            drain();
            set_idle(IDLE_NONE);
        end

        $display("run covered %0d points under %0d register settings, %0d results checked",
                 sb.points_noted, settings_loaded, sb.results_checked);
        $display("idle mixes: none, sender only, receiver only, both light");
        if (sb.errors == 0 && sb.expected_points.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
